FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the ray clip block.
// Depends on nothing; the file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RCP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define RCP_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define RCP_ASSERT(lbl, clk, rstn, prop, msg)
`define RCP_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: hw/rtl/rcp_pkg.sv
// Package of the ray convex polyhedron clip block: widths, register indexes
// and the face and result transfer types. Depends on nothing.
package rcp_pkg;

    localparam int COORD_WIDTH         = 16;
    localparam int FRACTION_BITS       = 8;
    localparam int PARAM_FRACTION_BITS = 16;

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int NORM_W  = 2 * COORD_WIDTH + 4;
    localparam int NLO_W   = NORM_W / 2;
    localparam int SEG_W   = 16 + COORD_WIDTH + 1 - FRACTION_BITS;
    localparam int ACC_W   = NORM_W + SEG_W + 2;
    localparam int MUL_A_W = NLO_W + 1;
    localparam int MUL_B_W = SEG_W;
    localparam int HT_W    = PARAM_FRACTION_BITS + 1;
    localparam int QUO_W   = PARAM_FRACTION_BITS + 2;
    localparam int T_W     = PARAM_FRACTION_BITS + 3;
    localparam int THR_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PAR_THRESH  = 3'd7;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_a_x;
        logic signed [COORD_WIDTH-1:0] vertex_a_y;
        logic signed [COORD_WIDTH-1:0] vertex_a_z;
        logic signed [COORD_WIDTH-1:0] vertex_b_x;
        logic signed [COORD_WIDTH-1:0] vertex_b_y;
        logic signed [COORD_WIDTH-1:0] vertex_b_z;
        logic signed [COORD_WIDTH-1:0] vertex_c_x;
        logic signed [COORD_WIDTH-1:0] vertex_c_y;
        logic signed [COORD_WIDTH-1:0] vertex_c_z;
        logic                          face_active;
        logic                          last_face;
    } face_t;

    typedef struct packed {
        logic                     hit;
        logic [HT_W-1:0]          hit_t;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
    } clip_result_t;

endpackage

FILE: hw/rtl/ray_convex_polyhedron_clip_top.sv
// Top level of the ray convex polyhedron clip block: one shared multiplier
// and accumulator under a step sequencer, then a restoring divider.
// Depends on rcp_pkg and assert_macros.svh.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      face_t, one face
//   m_       out        m_valid / m_ready      clip_result_t, one per last face
//   cfg_     in         cfg_we                 cfg_index, cfg_wdata
//
// An active face, unless the query is already rejected, runs the multiply steps
// of the sequencer (cross product, segment, two dot products), a drain and a
// decision state; when a quotient is needed, a setup state, one divide step per
// parameter fraction bit unless the setup settles the quotient, and an update
// follow. Skipped faces go from accept straight to finish. Reset is synchronous and active low.
// The result register lets the next face in while a result waits.
`include "assert_macros.svh"

module ray_convex_polyhedron_clip_top
    import rcp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  face_t                s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output clip_result_t         m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DRAIN, ST_DECIDE, ST_DIV_INIT, ST_DIV, ST_UPDATE, ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        S_UYVZ, S_UZVY, S_UZVX, S_UXVZ, S_UXVY, S_UYVX,
        S_MDX, S_MDY, S_MDZ,
        S_NXD_LO, S_NXD_HI, S_NYD_LO, S_NYD_HI, S_NZD_LO, S_NZD_HI,
        S_NXP_LO, S_NXP_HI, S_NYP_LO, S_NYP_HI, S_NZP_LO, S_NZP_HI
    } step_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_NX, DST_NY, DST_NZ, DST_DX, DST_DY, DST_DZ, DST_DEN, DST_DIST
    } dest_t;

    typedef struct packed {
        logic  valid;
        logic  clear;
        logic  neg;
        logic  hi;
        dest_t dest;
    } acc_ctl_t;

    localparam int DIV_CNT_W = $clog2(PARAM_FRACTION_BITS + 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PARAM_FRACTION_BITS - 1);
    localparam logic [HT_W-1:0] PARAM_ONE = HT_W'(1) << PARAM_FRACTION_BITS;
    localparam logic [HT_W-1:0] HT_MAX = {HT_W{1'b1}};

    state_t state_reg;
    step_t step_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic signed [COORD_WIDTH-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [COORD_WIDTH-1:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [15:0] max_dist_reg;
    logic [THR_W-1:0] thresh_reg;

    face_t item_reg;
    logic signed [NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [SEG_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [ACC_W-1:0] den_reg, dist_reg, acc_reg;
    logic signed [MUL_A_W+MUL_B_W-1:0] prod_reg;
    acc_ctl_t ctl_reg;

    logic [ACC_W-1:0] num_reg, dvs_reg, rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic neg_reg;

    logic [HT_W-1:0] entry_reg, exit_reg;
    logic signed [NORM_W-1:0] enx_reg, eny_reg, enz_reg;
    logic rejected_reg;

    logic m_valid_reg;
    clip_result_t m_data_reg;

    logic signed [DIFF_W-1:0] ux, uy, uz, vx, vy, vz, px, py, pz;
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    acc_ctl_t ctl_issue;
    logic signed [ACC_W-1:0] addend, acc_base, acc_next, seg_shift;

    logic [ACC_W-1:0] adenom, mag_dist;
    logic dist_pos;
    logic [ACC_W:0] rem_shift, dvs_twice;
    logic signed [T_W-1:0] t_val, entry_s, exit_s, new_exit;
    logic [HT_W-1:0] entry_new;
    logic emit;

    function automatic logic signed [MUL_A_W-1:0] n_lo(input logic signed [NORM_W-1:0] n);
        n_lo = $signed({1'b0, n[NLO_W-1:0]});
    endfunction

    function automatic logic signed [MUL_A_W-1:0] n_hi(input logic signed [NORM_W-1:0] n);
        n_hi = MUL_A_W'($signed(n[NORM_W-1:NLO_W]));
    endfunction

    always_comb begin
        ux = DIFF_W'(item_reg.vertex_b_x) - DIFF_W'(item_reg.vertex_a_x);
        uy = DIFF_W'(item_reg.vertex_b_y) - DIFF_W'(item_reg.vertex_a_y);
        uz = DIFF_W'(item_reg.vertex_b_z) - DIFF_W'(item_reg.vertex_a_z);
        vx = DIFF_W'(item_reg.vertex_c_x) - DIFF_W'(item_reg.vertex_a_x);
        vy = DIFF_W'(item_reg.vertex_c_y) - DIFF_W'(item_reg.vertex_a_y);
        vz = DIFF_W'(item_reg.vertex_c_z) - DIFF_W'(item_reg.vertex_a_z);
        px = DIFF_W'(origin_x_reg) - DIFF_W'(item_reg.vertex_a_x);
        py = DIFF_W'(origin_y_reg) - DIFF_W'(item_reg.vertex_a_y);
        pz = DIFF_W'(origin_z_reg) - DIFF_W'(item_reg.vertex_a_z);
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        ctl_issue = '{valid: (state_reg == ST_MUL), clear: 1'b1, neg: 1'b0, hi: 1'b0,
                      dest: DST_NONE};
        unique case (step_reg)
            S_UYVZ: begin op_a = MUL_A_W'(uy); op_b = MUL_B_W'(vz); end
            S_UZVY: begin
                op_a = MUL_A_W'(uz); op_b = MUL_B_W'(vy);
                ctl_issue.clear = 1'b0; ctl_issue.neg = 1'b1; ctl_issue.dest = DST_NX;
            end
            S_UZVX: begin op_a = MUL_A_W'(uz); op_b = MUL_B_W'(vx); end
            S_UXVZ: begin
                op_a = MUL_A_W'(ux); op_b = MUL_B_W'(vz);
                ctl_issue.clear = 1'b0; ctl_issue.neg = 1'b1; ctl_issue.dest = DST_NY;
            end
            S_UXVY: begin op_a = MUL_A_W'(ux); op_b = MUL_B_W'(vy); end
            S_UYVX: begin
                op_a = MUL_A_W'(uy); op_b = MUL_B_W'(vx);
                ctl_issue.clear = 1'b0; ctl_issue.neg = 1'b1; ctl_issue.dest = DST_NZ;
            end
            S_MDX: begin
                op_a = MUL_A_W'($signed({1'b0, max_dist_reg}));
                op_b = MUL_B_W'(dir_x_reg); ctl_issue.dest = DST_DX;
            end
            S_MDY: begin
                op_a = MUL_A_W'($signed({1'b0, max_dist_reg}));
                op_b = MUL_B_W'(dir_y_reg); ctl_issue.dest = DST_DY;
            end
            S_MDZ: begin
                op_a = MUL_A_W'($signed({1'b0, max_dist_reg}));
                op_b = MUL_B_W'(dir_z_reg); ctl_issue.dest = DST_DZ;
            end
            S_NXD_LO: begin op_a = n_lo(nx_reg); op_b = dx_reg; end
            S_NXD_HI: begin
                op_a = n_hi(nx_reg); op_b = dx_reg;
                ctl_issue.clear = 1'b0; ctl_issue.hi = 1'b1;
            end
            S_NYD_LO: begin op_a = n_lo(ny_reg); op_b = dy_reg; ctl_issue.clear = 1'b0; end
            S_NYD_HI: begin
                op_a = n_hi(ny_reg); op_b = dy_reg;
                ctl_issue.clear = 1'b0; ctl_issue.hi = 1'b1;
            end
            S_NZD_LO: begin op_a = n_lo(nz_reg); op_b = dz_reg; ctl_issue.clear = 1'b0; end
            S_NZD_HI: begin
                op_a = n_hi(nz_reg); op_b = dz_reg;
                ctl_issue.clear = 1'b0; ctl_issue.hi = 1'b1; ctl_issue.dest = DST_DEN;
            end
            S_NXP_LO: begin op_a = n_lo(nx_reg); op_b = MUL_B_W'(px); end
            S_NXP_HI: begin
                op_a = n_hi(nx_reg); op_b = MUL_B_W'(px);
                ctl_issue.clear = 1'b0; ctl_issue.hi = 1'b1;
            end
            S_NYP_LO: begin
                op_a = n_lo(ny_reg); op_b = MUL_B_W'(py); ctl_issue.clear = 1'b0;
            end
            S_NYP_HI: begin
                op_a = n_hi(ny_reg); op_b = MUL_B_W'(py);
                ctl_issue.clear = 1'b0; ctl_issue.hi = 1'b1;
            end
            S_NZP_LO: begin
                op_a = n_lo(nz_reg); op_b = MUL_B_W'(pz); ctl_issue.clear = 1'b0;
            end
            S_NZP_HI: begin
                op_a = n_hi(nz_reg); op_b = MUL_B_W'(pz);
                ctl_issue.clear = 1'b0; ctl_issue.hi = 1'b1; ctl_issue.dest = DST_DIST;
            end
            default: ctl_issue.valid = 1'b0;
        endcase
    end

    always_comb begin
        addend = ctl_reg.hi ? (ACC_W'(prod_reg) <<< NLO_W) : ACC_W'(prod_reg);
        acc_base = ctl_reg.clear ? '0 : acc_reg;
        acc_next = ctl_reg.neg ? acc_base - addend : acc_base + addend;
        seg_shift = acc_next >>> FRACTION_BITS;
    end

    always_comb begin
        adenom = den_reg[ACC_W-1] ? ACC_W'(-den_reg) : ACC_W'(den_reg);
        mag_dist = dist_reg[ACC_W-1] ? ACC_W'(-dist_reg) : ACC_W'(dist_reg);
        dist_pos = !dist_reg[ACC_W-1] && (dist_reg != '0);
        dvs_twice = {dvs_reg, 1'b0};
        rem_shift = {rem_reg, 1'b0};
        if (neg_reg) begin
            t_val = (quo_reg > QUO_W'(PARAM_ONE)) ? -T_W'(PARAM_ONE) : -T_W'(quo_reg);
        end else begin
            t_val = T_W'(quo_reg);
        end
        entry_s = T_W'(entry_reg);
        exit_s = T_W'(exit_reg);
        if (t_val > entry_s) begin
            entry_new = (t_val > T_W'(HT_MAX)) ? HT_MAX : t_val[HT_W-1:0];
        end else begin
            entry_new = entry_reg;
        end
        new_exit = (t_val < exit_s) ? t_val : exit_s;
    end

    assign emit = (state_reg == ST_FINISH) && item_reg.last_face && (!m_valid_reg || m_ready);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (ctl_reg.valid) begin
            acc_reg <= acc_next;
            unique case (ctl_reg.dest)
                DST_NX:   nx_reg <= acc_next[NORM_W-1:0];
                DST_NY:   ny_reg <= acc_next[NORM_W-1:0];
                DST_NZ:   nz_reg <= acc_next[NORM_W-1:0];
                DST_DX:   dx_reg <= seg_shift[SEG_W-1:0];
                DST_DY:   dy_reg <= seg_shift[SEG_W-1:0];
                DST_DZ:   dz_reg <= seg_shift[SEG_W-1:0];
                DST_DEN:  den_reg <= acc_next;
                DST_DIST: dist_reg <= acc_next;
                default: ;
            endcase
        end
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end

        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= S_UYVZ;
            div_cnt_reg <= '0;
            ctl_reg <= '{valid: 1'b0, clear: 1'b0, neg: 1'b0, hi: 1'b0, dest: DST_NONE};
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= COORD_WIDTH'(256);
            max_dist_reg <= 16'd256;
            thresh_reg <= THR_W'(1);
            entry_reg <= '0;
            exit_reg <= PARAM_ONE;
            enx_reg <= '0;
            eny_reg <= '0;
            enz_reg <= '0;
            rejected_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            ctl_reg <= ctl_issue;

            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ORIGIN_X:    origin_x_reg <= cfg_wdata[COORD_WIDTH-1:0];
                    CFG_ORIGIN_Y:    origin_y_reg <= cfg_wdata[COORD_WIDTH-1:0];
                    CFG_ORIGIN_Z:    origin_z_reg <= cfg_wdata[COORD_WIDTH-1:0];
                    CFG_DIRECTION_X: dir_x_reg <= cfg_wdata[COORD_WIDTH-1:0];
                    CFG_DIRECTION_Y: dir_y_reg <= cfg_wdata[COORD_WIDTH-1:0];
                    CFG_DIRECTION_Z: dir_z_reg <= cfg_wdata[COORD_WIDTH-1:0];
                    CFG_MAX_DIST:    max_dist_reg <= cfg_wdata[15:0];
                    CFG_PAR_THRESH:  thresh_reg <= cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && !emit) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        step_reg <= S_UYVZ;
                        state_reg <= (s_data.face_active && !rejected_reg) ? ST_MUL : ST_FINISH;
                    end
                end
                ST_MUL: begin
                    step_reg <= step_t'(step_reg + 5'd1);
                    if (step_reg == S_NZP_HI) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: state_reg <= ST_DECIDE;
                ST_DECIDE: begin
                    num_reg <= mag_dist;
                    dvs_reg <= adenom;
                    if (adenom < ACC_W'(thresh_reg) && dist_pos) begin
                        rejected_reg <= 1'b1;
                        state_reg <= ST_FINISH;
                    end else if (adenom <= ACC_W'(thresh_reg) || den_reg == '0) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_DIV_INIT;
                    end
                end
                ST_DIV_INIT: begin
                    div_cnt_reg <= '0;
                    neg_reg <= (dist_pos == !den_reg[ACC_W-1]) && (dist_reg != '0);
                    if (dist_reg == '0) begin
                        quo_reg <= '0;
                        state_reg <= ST_UPDATE;
                    end else if ({1'b0, num_reg} >= dvs_twice) begin
                        quo_reg <= QUO_W'(PARAM_ONE) << 1;
                        state_reg <= ST_UPDATE;
                    end else if (num_reg >= dvs_reg) begin
                        quo_reg <= QUO_W'(1);
                        rem_reg <= num_reg - dvs_reg;
                        state_reg <= ST_DIV;
                    end else begin
                        quo_reg <= '0;
                        rem_reg <= num_reg;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rem_shift >= {1'b0, dvs_reg}) begin
                        rem_reg <= ACC_W'(rem_shift - {1'b0, dvs_reg});
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift[ACC_W-1:0];
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_LAST) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (den_reg[ACC_W-1]) begin
                        if (t_val > entry_s) begin
                            enx_reg <= nx_reg;
                            eny_reg <= ny_reg;
                            enz_reg <= nz_reg;
                        end
                        entry_reg <= entry_new;
                        if (entry_new > exit_reg) begin
                            rejected_reg <= 1'b1;
                        end
                    end else begin
                        if (entry_s > new_exit) begin
                            rejected_reg <= 1'b1;
                        end
                        exit_reg <= new_exit[T_W-1] ? '0 : new_exit[HT_W-1:0];
                    end
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!item_reg.last_face) begin
                        state_reg <= ST_IDLE;
                    end else if (emit) begin
                        m_valid_reg <= 1'b1;
                        if (rejected_reg) begin
                            m_data_reg <= '0;
                        end else begin
                            m_data_reg <= '{hit: 1'b1, hit_t: entry_reg, normal_x: enx_reg,
                                            normal_y: eny_reg, normal_z: enz_reg};
                        end
                        entry_reg <= '0;
                        exit_reg <= PARAM_ONE;
                        enx_reg <= '0;
                        eny_reg <= '0;
                        enz_reg <= '0;
                        rejected_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `RCP_ASSERT(a_entry_le_exit, aclk, aresetn, !rejected_reg |-> entry_reg <= exit_reg,
        "entry passed exit without rejection")
    `RCP_ASSERT(a_clear_after_emit, aclk, aresetn,
        emit |=> (entry_reg == '0 && !rejected_reg && exit_reg == PARAM_ONE),
        "query state not cleared after a result")
    `RCP_ASSERT(a_miss_is_zero, aclk, aresetn,
        (m_valid && !m_data.hit) |-> (m_data.hit_t == '0 && m_data.normal_x == '0),
        "rejected result carries data")
    `RCP_NEVER(a_busy_no_ready, aclk, aresetn, s_ready && m_valid_reg && emit,
        "emit while input port is open")

endmodule
